### src/okec_pkg.sv
`timescale 1ns / 1ps

package okec_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;  // '#' escape for low bytes
  localparam logic [7:0] CH_TILDE = 8'h7e;  // '~' escape for high bytes
  localparam logic [7:0] CH_BANG  = 8'h21;  // '!' string terminator
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [15:0] COUNT_MAX = 16'hffff;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // results caused by one request, at most three
  typedef struct packed {
    logic [1:0]  cnt;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic        byte_valid;
    logic        string_done;
    logic        bad_escape;
    logic [15:0] consumed_count;
  } bundle_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h61 + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

  // returns {1'b1, 4'bx} style: bit 4 set when not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

endpackage

### src/okec_core.sv
`timescale 1ns / 1ps

module okec_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             step,
  input  logic [7:0]       item_byte,
  input  logic             item_eos,
  output okec_pkg::bundle_t bundle
);
  import okec_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  logic        mode;
  phase_t      phase, phase_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [15:0] consumed, consumed_next;

  logic        term;
  logic [4:0]  hv;
  logic [15:0] consumed_inc;

  assign term         = item_eos || item_byte == CH_BANG || item_byte == CH_NUL;
  assign hv           = item_eos ? 5'h10 : hex_value(item_byte);
  assign consumed_inc = (consumed == COUNT_MAX) ? consumed : consumed + 16'd1;

  always_comb begin
    bundle           = '0;
    phase_next       = phase;
    high_nibble_next = high_nibble;
    consumed_next    = consumed;
    if (mode == MODE_ENCODE) begin
      bundle.byte_valid = 1'b1;
      if (item_eos) begin
        bundle.cnt         = 2'd1;
        bundle.b0          = CH_BANG;
        bundle.string_done = 1'b1;
      end else if (item_byte <= CH_HASH || item_byte >= CH_TILDE) begin
        bundle.cnt = 2'd3;
        bundle.b0  = (item_byte <= CH_HASH) ? CH_HASH : CH_TILDE;
        bundle.b1  = hex_char(item_byte[7:4]);
        bundle.b2  = hex_char(item_byte[3:0]);
      end else begin
        bundle.cnt = 2'd1;
        bundle.b0  = item_byte;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (term) begin
            bundle.cnt            = 2'd1;
            bundle.string_done    = 1'b1;
            bundle.consumed_count = consumed;
            phase_next            = PH_IDLE;
            high_nibble_next      = '0;
            consumed_next         = '0;
          end else begin
            consumed_next = consumed_inc;
            if (item_byte == CH_HASH || item_byte == CH_TILDE) begin
              phase_next = PH_HIGH;
            end else begin
              bundle.cnt        = 2'd1;
              bundle.b0         = item_byte;
              bundle.byte_valid = 1'b1;
            end
          end
        end
        PH_SKIP: begin
          if (term) begin
            bundle.cnt         = 2'd1;
            bundle.string_done = 1'b1;
            bundle.bad_escape  = 1'b1;
            phase_next         = PH_IDLE;
            high_nibble_next   = '0;
            consumed_next      = '0;
          end
        end
        PH_HIGH, PH_LOW: begin
          if (hv[4]) begin
            bundle.cnt        = 2'd1;
            bundle.bad_escape = 1'b1;
            if (term) begin
              bundle.string_done = 1'b1;
              phase_next         = PH_IDLE;
              high_nibble_next   = '0;
              consumed_next      = '0;
            end else begin
              phase_next = PH_SKIP;
            end
          end else begin
            consumed_next = consumed_inc;
            if (phase == PH_HIGH) begin
              high_nibble_next = hv[3:0];
              phase_next       = PH_LOW;
            end else begin
              bundle.cnt        = 2'd1;
              bundle.b0         = {high_nibble, hv[3:0]};
              bundle.byte_valid = 1'b1;
              phase_next        = PH_IDLE;
              high_nibble_next  = '0;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_ENCODE;
      phase       <= PH_IDLE;
      high_nibble <= '0;
      consumed    <= '0;
    end else if (cfg_wr_en) begin
      mode        <= cfg_wr_data;
      phase       <= PH_IDLE;
      high_nibble <= '0;
      consumed    <= '0;
    end else if (step) begin
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
      consumed    <= consumed_next;
    end
  end

  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    step && bundle.string_done && mode == MODE_DECODE |=> phase == PH_IDLE && consumed == '0)
    else $error("decode state not cleared after string end");

  a_three_only_encode: assert property (@(posedge clk) disable iff (rst)
    bundle.cnt == 2'd3 |-> mode == MODE_ENCODE && !bundle.string_done)
    else $error("escape triple outside encode");

endmodule

### src/okec_out.sv
`timescale 1ns / 1ps

module okec_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  okec_pkg::bundle_t bundle,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              byte_valid,
  output logic              last_of_run,
  output logic              string_done,
  output logic              bad_escape,
  output logic [15:0]       consumed_count
);
  import okec_pkg::*;

  logic        valid;
  logic [1:0]  remaining;
  logic [7:0]  b0, b1, b2;
  logic        bv, done, bad;
  logic [15:0] count;
  logic        take;

  assign take = valid && !out_stall;
  assign free = !valid || (take && remaining == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      remaining <= '0;
    end else if (load) begin
      valid     <= 1'b1;
      remaining <= bundle.cnt;
    end else if (take) begin
      remaining <= remaining - 2'd1;
      if (remaining == 2'd1) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      b0    <= bundle.b0;
      b1    <= bundle.b1;
      b2    <= bundle.b2;
      bv    <= bundle.byte_valid;
      done  <= bundle.string_done;
      bad   <= bundle.bad_escape;
      count <= bundle.consumed_count;
    end else if (take) begin
      b0 <= b1;
      b1 <= b2;
    end
  end

  assign out_valid      = valid;
  assign out_byte       = b0;
  assign byte_valid     = bv;
  assign last_of_run    = remaining == 2'd1;
  assign string_done    = done;
  assign bad_escape     = bad;
  assign consumed_count = count;

  a_valid_has_beats: assert property (@(posedge clk) disable iff (rst)
    valid |-> remaining != 2'd0)
    else $error("output valid with no beats left");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    take && remaining == 2'd1 && !load |=> !valid)
    else $error("output still valid after last beat");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free && bundle.cnt != 2'd0)
    else $error("output loaded while busy or with no result");

endmodule

### src/ordered_key_escape_codec_core.sv
`timescale 1ns / 1ps

// order-preserving escape codec. cfg_wr_data selects the mode (0 encode, 1 decode);
// a write also resets the decode state. a request sits in an input register, is
// turned into its results combinationally and handed to a small output buffer, so
// decode and plain encode bytes run at one request per cycle while out_stall is
// low. an escaped encode byte yields three results ('#' or '~' and two hex
// digits) which leave the output buffer one at a time; the next request waits
// in the input register meanwhile. requests that produce no result (escape
// start, high digit, bytes skipped after an error) never wait on the output side.
module ordered_key_escape_codec_core (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_value,
  input  logic        end_of_string,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last_of_run,
  output logic        string_done,
  output logic        bad_escape,
  output logic [15:0] consumed_count
);
  import okec_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eos;

  bundle_t bundle;
  logic    out_free;
  logic    s1_adv;
  logic    accept;

  // a request with no result retires without touching the output buffer
  assign s1_adv   = s1_valid && (out_free || bundle.cnt == 2'd0);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= byte_value;
      s1_eos  <= end_of_string;
    end
  end

  // mode register, decode state and result generation
  okec_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .step       (s1_adv),
    .item_byte  (s1_byte),
    .item_eos   (s1_eos),
    .bundle     (bundle)
  );

  // result buffer, emits one result per cycle while out_stall is low
  okec_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (s1_adv && bundle.cnt != 2'd0),
    .bundle        (bundle),
    .free          (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .last_of_run   (last_of_run),
    .string_done   (string_done),
    .bad_escape    (bad_escape),
    .consumed_count(consumed_count)
  );

endmodule
